@@ sv/bpht_pkg.sv @@
// Shared types and constants of the bucketed process hash table.
// Used by the hash unit and the top level; depends on nothing.
package bpht_pkg;

  // Table geometry (bucket count must be a power of two)
  localparam int NumBuckets     = 64;
  localparam int SlotsPerBucket = 4;
  localparam int ProcessLimit   = 128;
  localparam int TotalSlots     = NumBuckets * SlotsPerBucket;

  localparam int BucketBits = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
  localparam int SlotBits   = (SlotsPerBucket > 1) ? $clog2(SlotsPerBucket) : 1;
  localparam int AddrBits   = (TotalSlots > 1) ? $clog2(TotalSlots) : 1;
  localparam int TotalBits  = $clog2(ProcessLimit + 1);

  // Hash constants
  localparam logic [31:0] MixMul = 32'd282563095;
  localparam logic [31:0] MixAdd = 32'd29634029;
  localparam logic [31:0] MixMod = 32'd993683819;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RES_OK          = 2'd0,
    RES_BUCKET_FULL = 2'd1,
    RES_TABLE_FULL  = 2'd2,
    RES_NOT_FOUND   = 2'd3
  } result_e;

  // Stored process record
  typedef struct packed {
    logic [7:0]  prio;
    logic [31:0] runtime;
    logic [31:0] pc;
    logic [31:0] sp;
    logic [31:0] status;
  } rec_t;

  localparam int RecBits = $bits(rec_t);

endpackage

@@ sv/bucketed_process_hash_table_unit.sv @@
// Top level of the bucketed process hash table: sequencer, slot scan,
// key and record RAMs. Depends on bpht_pkg, bpht_ram and bpht_hash.
//
// A command is taken when start is high and busy is low; busy stays high
// until the result is shown. The result is on the output ports for exactly
// one cycle, flagged by result_valid_o, and the receiver cannot stall it, so
// it must be captured then. Busy falls in the same cycle as the result
// shows. The hash multiplies, adds, then runs one compare plus up to four
// compare-subtract steps of the reduction. The check state tests the id and
// the process limit; a zero id, the no-op and an insert into a full table
// are answered there. Otherwise the scan reads the bucket one slot at a time
// through the registered RAM port, with a read state and a compare state
// per slot, up to four slots. Slot keys are cleared at reset through one
// valid flop per slot, so no clearing pass is needed.
module bucketed_process_hash_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [30:0] proc_id_i,
  input  logic [7:0]  prio_i,
  input  logic [31:0] virt_runtime_i,
  input  logic [31:0] saved_pc_i,
  input  logic [31:0] saved_sp_i,
  input  logic [31:0] saved_status_i,
  output logic        result_valid_o,
  output logic [1:0]  result_code_o,
  output logic [5:0]  bucket_index_o,
  output logic [1:0]  slot_index_o,
  output logic [7:0]  found_prio_o,
  output logic [31:0] found_runtime_o,
  output logic [31:0] found_pc_o,
  output logic [31:0] found_sp_o,
  output logic [31:0] found_status_o,
  output logic [7:0]  live_count_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HASH  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;

  logic [2:0] state_q, state_d;

  // Latched command
  bpht_pkg::op_e  op_q;
  logic [30:0]    id_q;
  bpht_pkg::rec_t rec_in_q;

  logic [bpht_pkg::BucketBits-1:0] bucket_q, bucket_d;
  logic [bpht_pkg::SlotBits-1:0]   slot_q, slot_d;
  logic [bpht_pkg::AddrBits-1:0]   rd_addr_q, addr_cur;
  logic [bpht_pkg::TotalBits-1:0]  total_q, total_d;
  logic [bpht_pkg::TotalSlots-1:0] valid_q, valid_d;

  // Hash unit
  logic                            hash_start, hash_done;
  logic [bpht_pkg::BucketBits-1:0] hash_bucket;

  // RAM ports
  logic                          mem_we;
  logic [30:0]                   key_rdata, key_eff, key_target;
  logic [bpht_pkg::RecBits-1:0]  rec_rdata_raw;
  bpht_pkg::rec_t                rec_rdata;
  logic                          key_match, last_slot, accept;

  // Result registers
  logic                         res_valid_q, res_valid_d;
  bpht_pkg::result_e            res_code_q, res_code_d;
  logic [bpht_pkg::SlotBits-1:0] res_slot_q, res_slot_d;
  bpht_pkg::rec_t               res_rec_q, res_rec_d;

  assign accept     = start && (state_q == S_IDLE);
  assign busy       = (state_q != S_IDLE);
  assign hash_start = accept;

  bpht_hash u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hash_start),
    .id_i     (proc_id_i),
    .done_o   (hash_done),
    .bucket_o (hash_bucket)
  );

  assign addr_cur = bpht_pkg::AddrBits'(int'(bucket_q) * bpht_pkg::SlotsPerBucket
                                        + int'(slot_q));

  bpht_ram #(
    .Width (31),
    .Depth (bpht_pkg::TotalSlots)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (rd_addr_q),
    .wdata_i (id_q),
    .raddr_i (addr_cur),
    .rdata_o (key_rdata)
  );

  bpht_ram #(
    .Width (bpht_pkg::RecBits),
    .Depth (bpht_pkg::TotalSlots)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (rd_addr_q),
    .wdata_i (rec_in_q),
    .raddr_i (addr_cur),
    .rdata_o (rec_rdata_raw)
  );

  assign rec_rdata = bpht_pkg::rec_t'(rec_rdata_raw);

  // An invalid slot reads as empty; insert looks for an empty key
  assign key_eff    = valid_q[rd_addr_q] ? key_rdata : 31'd0;
  assign key_target = (op_q == bpht_pkg::OP_INSERT) ? 31'd0 : id_q;
  assign key_match  = (key_eff == key_target);
  assign last_slot  = (slot_q == bpht_pkg::SlotBits'(bpht_pkg::SlotsPerBucket - 1));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    bucket_d    = bucket_q;
    slot_d      = slot_q;
    total_d     = total_q;
    valid_d     = valid_q;
    mem_we      = 1'b0;
    res_valid_d = 1'b0;
    res_code_d  = res_code_q;
    res_slot_d  = res_slot_q;
    res_rec_d   = res_rec_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          slot_d  = '0;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          bucket_d = hash_bucket;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if ((id_q == 31'd0) || (op_q == bpht_pkg::OP_NONE)) begin
          res_valid_d = 1'b1;
          res_code_d  = bpht_pkg::RES_NOT_FOUND;
          res_slot_d  = '0;
          res_rec_d   = '0;
          state_d     = S_IDLE;
        end else if ((op_q == bpht_pkg::OP_INSERT) &&
                     (total_q >= bpht_pkg::TotalBits'(bpht_pkg::ProcessLimit))) begin
          res_valid_d = 1'b1;
          res_code_d  = bpht_pkg::RES_TABLE_FULL;
          res_slot_d  = '0;
          res_rec_d   = '0;
          state_d     = S_IDLE;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        priority if (key_match) begin
          res_valid_d = 1'b1;
          res_code_d  = bpht_pkg::RES_OK;
          res_slot_d  = slot_q;
          res_rec_d   = '0;
          state_d     = S_IDLE;
          unique case (op_q)
            bpht_pkg::OP_INSERT: begin
              mem_we             = 1'b1;
              valid_d[rd_addr_q] = 1'b1;
              total_d            = total_q + 1'b1;
            end
            bpht_pkg::OP_DELETE: begin
              valid_d[rd_addr_q] = 1'b0;
              if (total_q != '0) total_d = total_q - 1'b1;
            end
            bpht_pkg::OP_FIND: begin
              res_rec_d = rec_rdata;
            end
            default: ;
          endcase
        end else if (last_slot) begin
          res_valid_d = 1'b1;
          res_code_d  = (op_q == bpht_pkg::OP_INSERT) ? bpht_pkg::RES_BUCKET_FULL
                                                       : bpht_pkg::RES_NOT_FOUND;
          res_slot_d  = '0;
          res_rec_d   = '0;
          state_d     = S_IDLE;
        end else begin
          slot_d  = slot_q + 1'b1;
          state_d = S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      valid_q     <= valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q             <= bpht_pkg::op_e'(operation_i);
      id_q             <= proc_id_i;
      rec_in_q.prio    <= prio_i;
      rec_in_q.runtime <= virt_runtime_i;
      rec_in_q.pc      <= saved_pc_i;
      rec_in_q.sp      <= saved_sp_i;
      rec_in_q.status  <= saved_status_i;
    end
    if (state_q == S_RD) rd_addr_q <= addr_cur;
    bucket_q   <= bucket_d;
    slot_q     <= slot_d;
    res_code_q <= res_code_d;
    res_slot_q <= res_slot_d;
    res_rec_q  <= res_rec_d;
  end

  // Live count and bucket index register with the result
  logic [7:0] live_q;
  logic [5:0] bucket_out_q;
  always_ff @(posedge clk_i) begin
    if (res_valid_d) begin
      live_q       <= 8'(total_d);
      bucket_out_q <= 6'(bucket_q);
    end
  end

  assign result_valid_o  = res_valid_q;
  assign result_code_o   = res_code_q;
  assign bucket_index_o  = bucket_out_q;
  assign slot_index_o    = 2'(res_slot_q);
  assign found_prio_o    = res_rec_q.prio;
  assign found_runtime_o = res_rec_q.runtime;
  assign found_pc_o      = res_rec_q.pc;
  assign found_sp_o      = res_rec_q.sp;
  assign found_status_o  = res_rec_q.status;
  assign live_count_o    = live_q;

endmodule

@@ sv/bpht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/bpht_hash.sv @@
// Bucket hash: one multiply, one add, then an iterative compare-subtract
// reduction modulo the mixing prime. Depends on bpht_pkg.
module bpht_hash (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [30:0]                     id_i,
  output logic                            done_o,
  output logic [bpht_pkg::BucketBits-1:0] bucket_o
);

  localparam logic [1:0] H_IDLE = 2'd0;
  localparam logic [1:0] H_MUL  = 2'd1;
  localparam logic [1:0] H_ADD  = 2'd2;
  localparam logic [1:0] H_RED  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [30:0] id_q;
  logic [31:0] prod_q, prod_d;
  logic [31:0] rem_q, rem_d;
  logic        ge_mod;

  // Shared compare-subtract unit
  assign ge_mod = (rem_q >= bpht_pkg::MixMod);

  always_comb begin
    state_d = state_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    done_o  = 1'b0;
    unique case (state_q)
      H_IDLE: begin
        if (start_i) state_d = H_MUL;
      end
      H_MUL: begin
        prod_d  = 32'({1'b0, id_q} * bpht_pkg::MixMul);
        state_d = H_ADD;
      end
      H_ADD: begin
        rem_d   = prod_q + bpht_pkg::MixAdd;
        state_d = H_RED;
      end
      H_RED: begin
        if (ge_mod) begin
          rem_d = rem_q - bpht_pkg::MixMod;
        end else begin
          done_o  = 1'b1;
          state_d = H_IDLE;
        end
      end
      default: state_d = H_IDLE;
    endcase
  end

  // Power-of-two bucket count: the final modulo is a mask
  assign bucket_o = rem_q[bpht_pkg::BucketBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == H_IDLE)) id_q <= id_i;
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

endmodule
